/* hw/rtl/b3s_pkg.sv */
// b3s_pkg: shared types, constants and packing helpers for the 3x3 binomial smoother.
// No dependencies; used by every module under hw/rtl.
package b3s_pkg;

    localparam int SAMPLE_W   = 24;   // bits per field component
    localparam int NCOMP      = 6;    // components per pixel
    localparam int COORD_W    = 10;   // width of out_row / out_col
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [NCOMP-1:0]        comp_vec_t;
    // one window column: [0] row r-2, [1] row r-1, [2] row r
    typedef comp_vec_t [2:0]            column_t;

    typedef struct packed {
        sample_t x_real;
        sample_t x_imag;
        sample_t y_real;
        sample_t y_imag;
        sample_t z_real;
        sample_t z_imag;
    } in_item_t;

    typedef struct packed {
        sample_t              sx_real;
        sample_t              sx_imag;
        sample_t              sy_real;
        sample_t              sy_imag;
        sample_t              sz_real;
        sample_t              sz_imag;
        logic [COORD_W-1:0]   out_row;
        logic [COORD_W-1:0]   out_col;
        logic                 run_last;
    } out_item_t;

    function automatic comp_vec_t item_to_vec(input in_item_t d);
        comp_vec_t v;
        v[0] = d.x_real;
        v[1] = d.x_imag;
        v[2] = d.y_real;
        v[3] = d.y_imag;
        v[4] = d.z_real;
        v[5] = d.z_imag;
        return v;
    endfunction

    function automatic out_item_t make_result(input comp_vec_t v,
                                              input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col,
                                              input logic last);
        out_item_t o;
        o.sx_real  = v[0];
        o.sx_imag  = v[1];
        o.sy_real  = v[2];
        o.sy_imag  = v[3];
        o.sz_real  = v[4];
        o.sz_imag  = v[5];
        o.out_row  = row;
        o.out_col  = col;
        o.run_last = last;
        return o;
    endfunction

endpackage

/* hw/rtl/b3s_line_store.sv */
// b3s_line_store: the two row buffers (rows r-2 and r-1), one pixel word per column.
// Depends on b3s_pkg. Read data registered; a same-cycle write to the read column is forwarded.
module b3s_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                aclk,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  b3s_pkg::comp_vec_t  wr_older,
    input  b3s_pkg::comp_vec_t  wr_prev,
    output b3s_pkg::comp_vec_t  rd_older,
    output b3s_pkg::comp_vec_t  rd_prev
);

    b3s_pkg::comp_vec_t older_mem [DEPTH];
    b3s_pkg::comp_vec_t prev_mem  [DEPTH];
    b3s_pkg::comp_vec_t rd_older_reg;
    b3s_pkg::comp_vec_t rd_prev_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            older_mem[wr_addr] <= wr_older;
            prev_mem[wr_addr]  <= wr_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_older_reg <= wr_older;
                rd_prev_reg  <= wr_prev;
            end else begin
                rd_older_reg <= older_mem[rd_addr];
                rd_prev_reg  <= prev_mem[rd_addr];
            end
        end
    end

    assign rd_older = rd_older_reg;
    assign rd_prev  = rd_prev_reg;

endmodule

/* hw/rtl/b3s_kernel.sv */
// b3s_kernel: 3x3 binomial weighting [1 2 1; 2 4 2; 1 2 1], rounded divide by 16.
// Depends on b3s_pkg. Purely combinational, one adder tree per component.
module b3s_kernel (
    input  b3s_pkg::column_t    left_col,
    input  b3s_pkg::column_t    mid_col,
    input  b3s_pkg::column_t    right_col,
    output b3s_pkg::comp_vec_t  smoothed
);

    localparam int CS_W  = b3s_pkg::SAMPLE_W + 2;
    localparam int SUM_W = b3s_pkg::SAMPLE_W + 4;

    for (genvar k = 0; k < b3s_pkg::NCOMP; k++) begin : g_comp
        logic signed [CS_W-1:0]  sum_l;
        logic signed [CS_W-1:0]  sum_m;
        logic signed [CS_W-1:0]  sum_r;
        logic signed [SUM_W-1:0] total;
        logic signed [SUM_W-1:0] biased;

        // vertical [1 2 1] per column
        assign sum_l = CS_W'(left_col[0][k]) + (CS_W'(left_col[1][k]) <<< 1)
                     + CS_W'(left_col[2][k]);
        assign sum_m = CS_W'(mid_col[0][k]) + (CS_W'(mid_col[1][k]) <<< 1)
                     + CS_W'(mid_col[2][k]);
        assign sum_r = CS_W'(right_col[0][k]) + (CS_W'(right_col[1][k]) <<< 1)
                     + CS_W'(right_col[2][k]);

        // horizontal [1 2 1], then +8 and arithmetic shift by 4
        assign total  = SUM_W'(sum_l) + (SUM_W'(sum_m) <<< 1) + SUM_W'(sum_r);
        assign biased = total + SUM_W'(8);
        assign smoothed[k] = biased[SUM_W-1:4];
    end

endmodule

/* hw/rtl/binomial_3x3_smoother.sv */
// binomial_3x3_smoother: streaming 3x3 binomial smoother over a row-major pixel raster.
// Depends on b3s_pkg, b3s_line_store and b3s_kernel.
//
//  channel | signals                        | moves
//  --------+--------------------------------+------------------------------------
//  s_      | s_valid, s_ready, s_data       | one pixel request (six components)
//  m_      | m_valid, m_ready, m_data       | one smoothed pixel with row/column
//  cfg_    | cfg_wr_en, cfg_index, cfg_wdata| frame_width / frame_height write
//
// Cycles: one request per cycle while each request yields at most one result and the
// m_ side is not stalled. A request on the last row or the last column yields up to
// four results; the single output register takes one per cycle while m_ready allows,
// so such a request holds s_ready low until its last result is loaded. A result
// passes the stage-1 register and the output register. Reset clears control state
// only; row-buffer words read before they are written never reach a result. A stalled
// m_ side fills the output register and then the stage-1 register; then s_ready drops.
module binomial_3x3_smoother #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [b3s_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [b3s_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // pixel requests in
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  b3s_pkg::in_item_t                    s_data,
    // results out
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output b3s_pkg::out_item_t                   m_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (MAX_WIDTH  < 64) ? MAX_WIDTH  : 64;
    localparam int H_RST = (MAX_HEIGHT < 64) ? MAX_HEIGHT : 64;
    localparam logic [CW-1:0] W_LAST_RST = CW'(W_RST - 1);
    localparam logic [RW-1:0] H_LAST_RST = RW'(H_RST - 1);
    localparam logic [CW-1:0] W_LAST_MAX = CW'(MAX_WIDTH - 1);
    localparam logic [RW-1:0] H_LAST_MAX = RW'(MAX_HEIGHT - 1);

    // ---------------- frame geometry and position of the next request ----------
    logic [CW-1:0] w_last_reg, w_last_cfg;
    logic [RW-1:0] h_last_reg, h_last_cfg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Dimension 0 acts as 1; anything above the maximum saturates. Stored as last index.
    always_comb begin
        if (cfg_wdata == '0) begin
            w_last_cfg = '0;
        end else if (int'(cfg_wdata) > MAX_WIDTH) begin
            w_last_cfg = W_LAST_MAX;
        end else begin
            w_last_cfg = CW'(cfg_wdata - 1'b1);
        end
        if (cfg_wdata == '0) begin
            h_last_cfg = '0;
        end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
            h_last_cfg = H_LAST_MAX;
        end else begin
            h_last_cfg = RW'(cfg_wdata - 1'b1);
        end
    end

    logic accept;
    logic row_nz, row_is_last, col_nz, col_is_last;

    assign accept      = s_valid && s_ready;
    assign row_nz      = (row_reg != '0);
    assign row_is_last = (row_reg == h_last_reg);
    assign col_nz      = (col_reg != '0);
    assign col_is_last = (col_reg == w_last_reg);

    always_comb begin
        if (col_is_last) begin
            col_next = '0;
            row_next = row_is_last ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    // a register write restarts the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= W_LAST_RST;
            h_last_reg <= H_LAST_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                b3s_pkg::CFG_FRAME_WIDTH: begin
                    w_last_reg <= w_last_cfg;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                b3s_pkg::CFG_FRAME_HEIGHT: begin
                    h_last_reg <= h_last_cfg;
                    col_reg    <= '0;
                    row_reg    <= '0;
                end
                default: ;
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Pending results of a request, in emission order:
    //   bit0 (r-1,c-1)  bit1 (r-1,c)  bit2 (r,c-1)  bit3 (r,c)
    // Row r only on the last row, column c only on the last column.
    logic [3:0] mask_in;
    assign mask_in = {row_is_last & col_is_last, row_is_last & col_nz,
                      row_nz & col_is_last,      row_nz & col_nz};

    // ---------------- stage 1: the request and its row-buffer words -----------
    logic                 s1_valid_reg, s1_valid_next;
    logic [3:0]           mask_reg, mask_next, mask_after;
    b3s_pkg::comp_vec_t   in_reg;
    logic [CW-1:0]        col_s1_reg;
    logic [RW-1:0]        row_s1_reg;
    logic                 inner_ok_reg;   // r >= 2 and c >= 2: (r-1,c-1) is interior
    b3s_pkg::comp_vec_t   older_rd, prev_rd;
    b3s_pkg::column_t     wc0_reg, wc1_reg, cur_col;
    b3s_pkg::comp_vec_t   kern_vec;

    logic [1:0] sel;       // lowest pending result; [1] row r, [0] column c
    logic       res_last;
    logic       emit;
    logic       s1_adv;

    always_comb begin
        if (mask_reg[0]) begin
            sel = 2'd0;
        end else if (mask_reg[1]) begin
            sel = 2'd1;
        end else if (mask_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
    end

    assign mask_after = mask_reg & ~(4'b0001 << sel);
    assign res_last   = (mask_after == '0);
    assign emit       = s1_valid_reg && (mask_reg != '0) && (!m_valid || m_ready);
    // leaves stage 1 once its last result is loaded, or at once if it has none
    assign s1_adv     = s1_valid_reg && ((mask_reg == '0) || (emit && res_last));
    assign s_ready    = !s1_valid_reg || s1_adv;

    assign s1_valid_next = accept || (s1_valid_reg && !s1_adv);
    assign mask_next     = accept ? mask_in : (emit ? mask_after : mask_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            mask_reg     <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg       <= b3s_pkg::item_to_vec(s_data);
            col_s1_reg   <= col_reg;
            row_s1_reg   <= row_reg;
            inner_ok_reg <= (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        end
    end

    // row buffers: on leaving, row r-1 moves down to r-2 and the request becomes r-1
    b3s_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk     (aclk),
        .rd_en    (accept),
        .rd_addr  (col_reg),
        .wr_en    (s1_adv),
        .wr_addr  (col_s1_reg),
        .wr_older (prev_rd),
        .wr_prev  (in_reg),
        .rd_older (older_rd),
        .rd_prev  (prev_rd)
    );

    assign cur_col[0] = older_rd;
    assign cur_col[1] = prev_rd;
    assign cur_col[2] = in_reg;

    // window columns c-2 and c-1 shift when the request leaves
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            wc0_reg <= wc1_reg;
            wc1_reg <= cur_col;
        end
    end

    b3s_kernel u_kernel (
        .left_col  (wc0_reg),
        .mid_col   (wc1_reg),
        .right_col (cur_col),
        .smoothed  (kern_vec)
    );

    // ---------------- result selection and output register ---------------------
    logic                        interior;
    b3s_pkg::comp_vec_t          res_vec;
    logic [RW-1:0]               res_row;
    logic [CW-1:0]               res_col;
    logic                        m_valid_reg, m_valid_next;
    b3s_pkg::out_item_t          m_data_reg;

    // only (r-1,c-1) can be interior; borders pass the stored sample through
    assign interior = !sel[1] && !sel[0] && inner_ok_reg;
    assign res_row  = sel[1] ? row_s1_reg : row_s1_reg - 1'b1;
    assign res_col  = sel[0] ? col_s1_reg : col_s1_reg - 1'b1;

    always_comb begin
        if (interior) begin
            res_vec = kern_vec;
        end else if (sel[0]) begin
            res_vec = sel[1] ? in_reg : prev_rd;
        end else begin
            res_vec = sel[1] ? wc1_reg[2] : wc1_reg[1];
        end
    end

    assign m_valid_next = emit || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= b3s_pkg::make_result(res_vec,
                                               b3s_pkg::COORD_W'(res_row),
                                               b3s_pkg::COORD_W'(res_col),
                                               res_last);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
